### hw/rtl/usvig_pkg.sv
// Shared types, constants and helper functions of the UV sphere vertex index generator.
// Used by usvig_ctrl, usvig_dp and the top level; depends on nothing else.
package usvig_pkg;

    // Width of the bit-serial divider's dividend (segment index shifted by a full turn).
    localparam int DIV_W        = 44;
    localparam int CORDIC_STEPS = 30;

    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [32:0] ONE_Q30     = 33'sd1073741824;
    localparam logic signed [63:0] S32_MAX     = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN     = -64'sd2147483648;

    // Configuration register indexes.
    localparam logic [2:0] CFG_U_SEGMENTS = 3'd0;
    localparam logic [2:0] CFG_V_SEGMENTS = 3'd1;
    localparam logic [2:0] CFG_RADIUS     = 3'd2;
    localparam logic [2:0] CFG_CENTER_X   = 3'd3;
    localparam logic [2:0] CFG_CENTER_Y   = 3'd4;
    localparam logic [2:0] CFG_CENTER_Z   = 3'd5;
    localparam logic [2:0] CFG_RANDOMNESS = 3'd6;
    localparam logic [2:0] CFG_ATTR_EN    = 3'd7;

    // Vertex component codes.
    localparam logic [3:0] COMP_POS_X   = 4'd0;
    localparam logic [3:0] COMP_POS_Y   = 4'd1;
    localparam logic [3:0] COMP_POS_Z   = 4'd2;
    localparam logic [3:0] COMP_TEX_U   = 4'd3;
    localparam logic [3:0] COMP_TEX_V   = 4'd4;
    localparam logic [3:0] COMP_NRM_X   = 4'd5;
    localparam logic [3:0] COMP_NRM_Y   = 4'd6;
    localparam logic [3:0] COMP_NRM_Z   = 4'd7;
    localparam logic [3:0] COMP_TAN_X   = 4'd8;
    localparam logic [3:0] COMP_TAN_Y   = 4'd9;
    localparam logic [3:0] COMP_TAN_Z   = 4'd10;
    localparam logic [3:0] COMP_BTAN_X  = 4'd11;
    localparam logic [3:0] COMP_BTAN_Y  = 4'd12;
    localparam logic [3:0] COMP_BTAN_Z  = 4'd13;

    // Triangle index slots of a quad.
    localparam logic [3:0] SLOT_A0 = 4'd0;
    localparam logic [3:0] SLOT_A1 = 4'd1;
    localparam logic [3:0] SLOT_A2 = 4'd2;
    localparam logic [3:0] SLOT_B0 = 4'd3;
    localparam logic [3:0] SLOT_B1 = 4'd4;
    localparam logic [3:0] SLOT_B2 = 4'd5;

    // Micro-operations, in the order a vertex runs them.
    typedef enum logic [3:0] {
        OP_DIV_VPH,
        OP_DIV_UPH,
        OP_DIV_TEXU,
        OP_DIV_TEXV,
        OP_COR_V,
        OP_COR_U,
        OP_MUL_G,
        OP_MUL_SR,
        OP_MUL_NX,
        OP_MUL_NZ,
        OP_MUL_T11,
        OP_MUL_T13,
        OP_MUL_PX,
        OP_MUL_PY,
        OP_MUL_PZ,
        OP_MUL_K
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ISSUE,
        ST_WAIT,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       start;
        t_op        op;
        logic       emit;
        logic [3:0] comp;
        logic       last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic        done;
        logic        action;
        logic [13:0] mask;
        logic        out_free;
    } t_status;

    // Arctangent of 2^-k as a fraction of a turn, 32-bit turn scale.
    function automatic logic [29:0] atan_turn(input logic [4:0] k);
        logic [29:0] a;
        case (k)
            5'd0:    a = 30'h20000000;
            5'd1:    a = 30'h12E4051D;
            5'd2:    a = 30'h09FB385B;
            5'd3:    a = 30'h051111D4;
            5'd4:    a = 30'h028B0D43;
            5'd5:    a = 30'h0145D7E1;
            5'd6:    a = 30'h00A2F61E;
            5'd7:    a = 30'h00517C55;
            5'd8:    a = 30'h0028BE53;
            5'd9:    a = 30'h00145F2E;
            5'd10:   a = 30'h000A2F98;
            5'd11:   a = 30'h000517CC;
            5'd12:   a = 30'h00028BE6;
            5'd13:   a = 30'h000145F3;
            5'd14:   a = 30'h0000A2F9;
            5'd15:   a = 30'h0000517C;
            5'd16:   a = 30'h000028BE;
            5'd17:   a = 30'h0000145F;
            5'd18:   a = 30'h00000A2F;
            5'd19:   a = 30'h00000517;
            5'd20:   a = 30'h0000028B;
            5'd21:   a = 30'h00000145;
            5'd22:   a = 30'h000000A2;
            5'd23:   a = 30'h00000051;
            5'd24:   a = 30'h00000028;
            5'd25:   a = 30'h00000014;
            5'd26:   a = 30'h0000000A;
            5'd27:   a = 30'h00000005;
            5'd28:   a = 30'h00000002;
            5'd29:   a = 30'h00000001;
            default: a = 30'h0;
        endcase
        return a;
    endfunction

    // Round to nearest by adding half an LSB, then floor.
    function automatic logic signed [63:0] rnd64(input logic signed [63:0] v, input int k);
        return (v + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    // Saturate to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > S32_MAX) begin
            r = S32_MAX;
        end else if (v < S32_MIN) begin
            r = S32_MIN;
        end else begin
            r = v;
        end
        return r[31:0];
    endfunction

endpackage

### hw/rtl/usvig_ctrl.sv
// Sequencing state machine of the UV sphere vertex index generator.
// Depends on usvig_pkg; drives the datapath usvig_dp through t_cmd and reads t_status.
module usvig_ctrl
    import usvig_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    t_state     r_state, n_state;
    t_op        r_op, n_op;
    logic [3:0] r_comp, n_comp;
    logic       rest_zero;

    // No enabled word remains above the current component.
    assign rest_zero = (i_status.mask & ~((14'd2 << r_comp) - 14'd1)) == 14'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_DIV_VPH;
            r_comp  <= 4'd0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_comp  <= n_comp;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_comp  = r_comp;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_op    = i_status.action ? OP_MUL_K : OP_DIV_VPH;
                n_state = ST_ISSUE;
            end
            ST_ISSUE: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_status.done) begin
                    if (r_op == OP_MUL_PZ || r_op == OP_MUL_K) begin
                        n_state = ST_EMIT;
                        n_comp  = 4'd0;
                    end else begin
                        n_op    = t_op'(r_op + 4'd1);
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_EMIT: begin
                if (i_status.mask == 14'd0) begin
                    n_state = ST_IDLE;
                end else if (!i_status.mask[r_comp]) begin
                    n_comp = r_comp + 4'd1;
                end else if (i_status.out_free) begin
                    if (rest_zero) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_comp = r_comp + 4'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd.load  = 1'b0;
        o_cmd.start = 1'b0;
        o_cmd.op    = r_op;
        o_cmd.emit  = 1'b0;
        o_cmd.comp  = r_comp;
        o_cmd.last  = rest_zero;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_ISSUE: begin
                o_cmd.start = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit = (i_status.mask != 14'd0) && i_status.mask[r_comp]
                             && i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/usvig_dp.sv
// Datapath of the UV sphere vertex index generator: configuration, divider, CORDIC,
// multiplier, vertex state and the output word register. Depends on usvig_pkg.
module usvig_dp
    import usvig_pkg::*;
#(
    parameter int MAX_SEGMENTS  = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_action,
    input  logic [10:0]        i_row,
    input  logic [10:0]        i_column,
    input  logic [15:0]        i_shift,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [31:0] o_value,
    output logic [3:0]         o_component,
    output logic               o_last,
    input  t_cmd               i_cmd,
    output t_status            o_status
);

    localparam int SH      = 30 - FRACTION_BITS;
    localparam int QW      = 12 + FRACTION_BITS;
    localparam int SEG_CAP = (MAX_SEGMENTS > 2047) ? 2047 : MAX_SEGMENTS;

    // Configuration registers.
    logic [10:0]        r_u_seg, r_v_seg;
    logic [30:0]        r_radius;
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [15:0]        r_rand;
    logic [2:0]         r_attr;

    // Latched item and state across items.
    logic               r_action;
    logic [10:0]        r_row, r_col;
    logic [15:0]        r_shift, r_pole_shift;
    logic signed [31:0] r_rfp [3];

    // Intermediate results.
    logic [31:0]        r_vph, r_uph;
    logic signed [31:0] r_texu, r_texv;
    logic signed [31:0] r_cv, r_sv, r_cu, r_su;
    logic signed [32:0] r_g, r_sr;
    logic signed [31:0] r_nx, r_nz, r_t11, r_t13, r_px, r_py, r_pz;
    logic [21:0]        r_k1;

    logic [10:0] us, vs;

    // Segment counts clamped to one up to the supported maximum.
    always_comb begin
        us = r_u_seg;
        vs = r_v_seg;
        if (r_u_seg == 11'd0) begin
            us = 11'd1;
        end else if (r_u_seg > SEG_CAP) begin
            us = SEG_CAP[10:0];
        end
        if (r_v_seg == 11'd0) begin
            vs = 11'd1;
        end else if (r_v_seg > SEG_CAP) begin
            vs = SEG_CAP[10:0];
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_seg  <= 11'd16;
            r_v_seg  <= 11'd16;
            r_radius <= 31'd65536;
            r_cx     <= 32'sd0;
            r_cy     <= 32'sd0;
            r_cz     <= 32'sd0;
            r_rand   <= 16'd0;
            r_attr   <= 3'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_U_SEGMENTS: r_u_seg  <= i_cfg_data[10:0];
                CFG_V_SEGMENTS: r_v_seg  <= i_cfg_data[10:0];
                CFG_RADIUS:     r_radius <= i_cfg_data[30:0];
                CFG_CENTER_X:   r_cx     <= i_cfg_data;
                CFG_CENTER_Y:   r_cy     <= i_cfg_data;
                CFG_CENTER_Z:   r_cz     <= i_cfg_data;
                CFG_RANDOMNESS: r_rand   <= i_cfg_data[15:0];
                CFG_ATTR_EN:    r_attr   <= i_cfg_data[2:0];
                default:        r_attr   <= r_attr;
            endcase
        end
    end

    // Item latch; pole rows take the shift latched at column zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pole_shift <= 16'd0;
        end else if (i_cmd.load && !i_action && (i_row == 11'd0 || i_row == vs)
                     && i_column == 11'd0) begin
            r_pole_shift <= i_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_row    <= i_row;
            r_col    <= i_column;
            if (!i_action && (i_row == 11'd0 || i_row == vs) && i_column != 11'd0) begin
                r_shift <= r_pole_shift;
            end else begin
                r_shift <= i_shift;
            end
        end
    end

    logic op_div, op_cor, op_mul;
    assign op_div = i_cmd.op == OP_DIV_VPH || i_cmd.op == OP_DIV_UPH
                 || i_cmd.op == OP_DIV_TEXU || i_cmd.op == OP_DIV_TEXV;
    assign op_cor = i_cmd.op == OP_COR_V || i_cmd.op == OP_COR_U;
    assign op_mul = !op_div && !op_cor;

    // ---------------- Restoring divider, one quotient bit a cycle.
    logic             r_div_busy;
    logic [5:0]       r_div_cnt;
    logic [10:0]      r_div_rem, r_dvs;
    logic [DIV_W-1:0] r_div_q;
    t_op              r_div_op;
    logic [DIV_W-1:0] dvd;
    logic [10:0]      dvs;
    logic [11:0]      dv_t;
    logic             dv_ge;
    logic [11:0]      dv_rem;
    logic [DIV_W-1:0] dv_q;
    logic             div_fin;
    logic signed [63:0] tex_diff;

    // Dividend and divisor of each division.
    always_comb begin
        case (i_cmd.op)
            OP_DIV_VPH: begin
                dvd = ({{(DIV_W-11){1'b0}}, r_row} << 31) + {{(DIV_W-10){1'b0}}, vs[10:1]};
                dvs = vs;
            end
            OP_DIV_UPH: begin
                dvd = ({{(DIV_W-11){1'b0}}, r_col} << 32) + {{(DIV_W-10){1'b0}}, us[10:1]};
                dvs = us;
            end
            OP_DIV_TEXU: begin
                dvd = ({{(DIV_W-11){1'b0}}, r_col} << FRACTION_BITS)
                    + {{(DIV_W-10){1'b0}}, us[10:1]};
                dvs = us;
            end
            default: begin
                dvd = ({{(DIV_W-11){1'b0}}, r_row} << FRACTION_BITS)
                    + {{(DIV_W-10){1'b0}}, vs[10:1]};
                dvs = vs;
            end
        endcase
    end

    assign dv_t    = {r_div_rem, r_div_q[DIV_W-1]};
    assign dv_ge   = dv_t >= {1'b0, r_dvs};
    assign dv_rem  = dv_ge ? dv_t - {1'b0, r_dvs} : dv_t;
    assign dv_q    = {r_div_q[DIV_W-2:0], dv_ge};
    assign div_fin = r_div_busy && r_div_cnt == 6'(DIV_W - 1);
    assign tex_diff = (64'sd1 <<< FRACTION_BITS) - $signed({{(64-QW){1'b0}}, dv_q[QW-1:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
        end else if (i_cmd.start && op_div) begin
            r_div_busy <= 1'b1;
        end else if (div_fin) begin
            r_div_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start && op_div) begin
            r_div_q   <= dvd;
            r_dvs     <= dvs;
            r_div_rem <= 11'd0;
            r_div_cnt <= 6'd0;
            r_div_op  <= i_cmd.op;
        end else if (r_div_busy) begin
            r_div_q   <= dv_q;
            r_div_rem <= dv_rem[10:0];
            r_div_cnt <= r_div_cnt + 6'd1;
        end
        if (div_fin) begin
            case (r_div_op)
                OP_DIV_VPH:  r_vph  <= 32'h4000_0000 - dv_q[31:0];
                OP_DIV_UPH:  r_uph  <= dv_q[31:0];
                OP_DIV_TEXU: r_texu <= sat32(tex_diff);
                default:     r_texv <= sat32(tex_diff);
            endcase
        end
    end

    // ---------------- CORDIC rotation, one step a cycle.
    logic               r_cor_busy;
    logic [4:0]         r_cr_k;
    logic signed [32:0] r_cr_x, r_cr_y, r_cr_z;
    logic [1:0]         r_cr_quad;
    t_op                r_cor_op;
    logic signed [32:0] cr_dx, cr_dy, cr_at, cr_xn, cr_yn, cr_zn;
    logic signed [31:0] cr_xc, cr_yc, cr_c, cr_s;
    logic [31:0]        cr_phase;
    logic               cor_fin;

    function automatic logic signed [31:0] clamp_unit(input logic signed [32:0] v);
        logic signed [32:0] r;
        if (v > ONE_Q30) begin
            r = ONE_Q30;
        end else if (v < -ONE_Q30) begin
            r = -ONE_Q30;
        end else begin
            r = v;
        end
        return r[31:0];
    endfunction

    assign cr_phase = (i_cmd.op == OP_COR_V) ? r_vph : r_uph;
    assign cr_dx    = r_cr_y >>> r_cr_k;
    assign cr_dy    = r_cr_x >>> r_cr_k;
    assign cr_at    = $signed({3'b000, atan_turn(r_cr_k)});
    assign cr_xn    = r_cr_z[32] ? r_cr_x + cr_dx : r_cr_x - cr_dx;
    assign cr_yn    = r_cr_z[32] ? r_cr_y - cr_dy : r_cr_y + cr_dy;
    assign cr_zn    = r_cr_z[32] ? r_cr_z + cr_at : r_cr_z - cr_at;
    assign cor_fin  = r_cor_busy && r_cr_k == 5'(CORDIC_STEPS - 1);
    assign cr_xc    = clamp_unit(cr_xn);
    assign cr_yc    = clamp_unit(cr_yn);

    // Quadrant of the phase folds the first-quadrant result.
    always_comb begin
        case (r_cr_quad)
            2'd0:    begin cr_c = cr_xc;  cr_s = cr_yc;  end
            2'd1:    begin cr_c = -cr_yc; cr_s = cr_xc;  end
            2'd2:    begin cr_c = -cr_xc; cr_s = -cr_yc; end
            default: begin cr_c = cr_yc;  cr_s = -cr_xc; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cor_busy <= 1'b0;
        end else if (i_cmd.start && op_cor) begin
            r_cor_busy <= 1'b1;
        end else if (cor_fin) begin
            r_cor_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start && op_cor) begin
            r_cr_x    <= CORDIC_GAIN;
            r_cr_y    <= 33'sd0;
            r_cr_z    <= $signed({3'b000, cr_phase[29:0]});
            r_cr_quad <= cr_phase[31:30];
            r_cr_k    <= 5'd0;
            r_cor_op  <= i_cmd.op;
        end else if (r_cor_busy) begin
            r_cr_x <= cr_xn;
            r_cr_y <= cr_yn;
            r_cr_z <= cr_zn;
            r_cr_k <= r_cr_k + 5'd1;
        end
        if (cor_fin) begin
            if (r_cor_op == OP_COR_V) begin
                r_cv <= cr_c;
                r_sv <= cr_s;
            end else begin
                r_cu <= cr_c;
                r_su <= cr_s;
            end
        end
    end

    // ---------------- Shared multiplier: product registered, then rounded and stored.
    logic               r_mul_pend;
    t_op                r_mul_op;
    logic signed [63:0] r_prod;
    logic signed [32:0] ma, mb;
    logic signed [65:0] mprod;
    logic signed [63:0] mr30, mr31, sr_full;
    logic signed [31:0] px_val, py_val, pz_val;
    logic signed [16:0] shift_c;

    assign shift_c = $signed({1'b0, r_shift}) - 17'sd32768;

    // Operand selection for each product.
    always_comb begin
        case (i_cmd.op)
            OP_MUL_G:   begin ma = {{16{shift_c[16]}}, shift_c}; mb = {17'd0, r_rand}; end
            OP_MUL_SR:  begin ma = {2'b00, r_radius}; mb = r_g; end
            OP_MUL_NX:  begin ma = {r_cv[31], r_cv}; mb = {r_cu[31], r_cu}; end
            OP_MUL_NZ:  begin ma = {r_cv[31], r_cv}; mb = {r_su[31], r_su}; end
            OP_MUL_T11: begin ma = -{r_sv[31], r_sv}; mb = {r_cu[31], r_cu}; end
            OP_MUL_T13: begin ma = -{r_sv[31], r_sv}; mb = {r_su[31], r_su}; end
            OP_MUL_PX:  begin ma = r_sr; mb = {r_nx[31], r_nx}; end
            OP_MUL_PY:  begin ma = r_sr; mb = {r_sv[31], r_sv}; end
            OP_MUL_PZ:  begin ma = r_sr; mb = {r_nz[31], r_nz}; end
            default:    begin ma = {22'd0, r_row}; mb = {21'd0, {1'b0, us} + 12'd1}; end
        endcase
    end

    assign mprod   = ma * mb;
    assign mr30    = rnd64(r_prod, 30);
    assign mr31    = rnd64(r_prod, 31);
    assign sr_full = $signed({33'd0, r_radius}) + mr31;
    assign px_val  = sat32(mr30 + {{32{r_cx[31]}}, r_cx});
    assign py_val  = sat32(mr30 + {{32{r_cy[31]}}, r_cy});
    assign pz_val  = sat32(mr30 + {{32{r_cz[31]}}, r_cz});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_pend <= 1'b0;
        end else begin
            r_mul_pend <= i_cmd.start && op_mul;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start && op_mul) begin
            r_prod   <= mprod[63:0];
            r_mul_op <= i_cmd.op;
        end
        if (r_mul_pend) begin
            case (r_mul_op)
                OP_MUL_G:   r_g   <= r_prod[32:0];
                OP_MUL_SR:  r_sr  <= sr_full[32:0];
                OP_MUL_NX:  r_nx  <= mr30[31:0];
                OP_MUL_NZ:  r_nz  <= mr30[31:0];
                OP_MUL_T11: r_t11 <= mr30[31:0];
                OP_MUL_T13: r_t13 <= mr30[31:0];
                OP_MUL_PX:  r_px  <= px_val;
                OP_MUL_PY:  r_py  <= py_val;
                OP_MUL_PZ:  r_pz  <= pz_val;
                default:    r_k1  <= r_prod[21:0] + {11'd0, r_col};
            endcase
        end
    end

    // The first position of a row is kept for the seam column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rfp[0] <= 32'sd0;
            r_rfp[1] <= 32'sd0;
            r_rfp[2] <= 32'sd0;
        end else if (r_mul_pend && r_mul_op == OP_MUL_PZ && r_col == 11'd0) begin
            r_rfp[0] <= r_px;
            r_rfp[1] <= r_py;
            r_rfp[2] <= pz_val;
        end
    end

    // ---------------- Word selection and enable mask.
    logic               seam, q_ok, q_top, q_bot;
    logic [21:0]        k2;
    logic signed [31:0] emit_val;
    logic signed [63:0] nrm_x, nrm_y, nrm_z, tan_x, tan_z, bt_x, bt_y, bt_z;

    assign seam  = r_col == us;
    assign q_ok  = (r_row < vs) && (r_col < us);
    assign q_top = q_ok && r_row != 11'd0;
    assign q_bot = q_ok && r_row != vs - 11'd1;
    assign k2    = r_k1 + {10'd0, {1'b0, us} + 12'd1};
    assign nrm_x = rnd64({{32{r_nx[31]}}, r_nx}, SH);
    assign nrm_y = rnd64({{32{r_sv[31]}}, r_sv}, SH);
    assign nrm_z = rnd64({{32{r_nz[31]}}, r_nz}, SH);
    assign tan_x = rnd64({{32{r_su[31]}}, r_su}, SH);
    assign tan_z = rnd64({{32{r_cu[31]}}, r_cu}, SH);
    assign bt_x  = rnd64({{32{r_t11[31]}}, r_t11}, SH);
    assign bt_y  = rnd64({{32{r_cv[31]}}, r_cv}, SH);
    assign bt_z  = rnd64({{32{r_t13[31]}}, r_t13}, SH);

    always_comb begin
        if (r_action) begin
            case (i_cmd.comp)
                SLOT_A0: emit_val = {10'd0, r_k1};
                SLOT_A1: emit_val = {10'd0, r_k1 + 22'd1};
                SLOT_A2: emit_val = {10'd0, k2};
                SLOT_B0: emit_val = {10'd0, r_k1 + 22'd1};
                SLOT_B1: emit_val = {10'd0, k2 + 22'd1};
                SLOT_B2: emit_val = {10'd0, k2};
                default: emit_val = 32'sd0;
            endcase
        end else begin
            case (i_cmd.comp)
                COMP_POS_X:  emit_val = seam ? r_rfp[0] : r_px;
                COMP_POS_Y:  emit_val = seam ? r_rfp[1] : r_py;
                COMP_POS_Z:  emit_val = seam ? r_rfp[2] : r_pz;
                COMP_TEX_U:  emit_val = r_texu;
                COMP_TEX_V:  emit_val = r_texv;
                COMP_NRM_X:  emit_val = nrm_x[31:0];
                COMP_NRM_Y:  emit_val = nrm_y[31:0];
                COMP_NRM_Z:  emit_val = nrm_z[31:0];
                COMP_TAN_X:  emit_val = tan_x[31:0];
                COMP_TAN_Y:  emit_val = 32'sd0;
                COMP_TAN_Z:  emit_val = tan_z[31:0];
                COMP_BTAN_X: emit_val = bt_x[31:0];
                COMP_BTAN_Y: emit_val = bt_y[31:0];
                COMP_BTAN_Z: emit_val = bt_z[31:0];
                default:     emit_val = 32'sd0;
            endcase
        end
    end

    // ---------------- Output word register.
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_value     <= emit_val;
            o_component <= i_cmd.comp;
            o_last      <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;

    assign o_status.done     = div_fin || cor_fin || r_mul_pend;
    assign o_status.action   = r_action;
    assign o_status.mask     = r_action
        ? {8'd0, {3{q_bot}}, {3{q_top}}}
        : {{6{r_attr[2]}}, {3{r_attr[1]}}, {2{r_attr[0]}}, 3'b111};
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

### hw/rtl/uv_sphere_vertex_index_generator.sv
// UV sphere vertex and triangle index generator, top level.
// Depends on usvig_pkg, usvig_ctrl and usvig_dp.
//
// One grid point or quad is taken at a time. A vertex word set runs through a setup state,
// four 44-step bit-serial divisions for the two phases and two texcoords, two 30-step
// CORDIC runs and nine products through the shared multiplier; the emit state then scans
// the component indexes and waits out any output stalls. A quad runs one product for its
// base index and then scans its index slots. Results leave through a single output word
// register, so the next item is accepted while the final word still waits. Texcoord,
// normal, tangent and bitangent words are Q16.16 when FRACTION_BITS is 16; positions take
// the radius and center scale, index words are integers; no clearing pass follows reset.
module uv_sphere_vertex_index_generator
    import usvig_pkg::*;
#(
    parameter int MAX_SEGMENTS  = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic [10:0]        i_row,
    input  logic [10:0]        i_column,
    input  logic [15:0]        i_shift,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_value,
    output logic [3:0]         o_component,
    output logic               o_last,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    usvig_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    usvig_dp #(
        .MAX_SEGMENTS  (MAX_SEGMENTS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_action    (i_action),
        .i_row       (i_row),
        .i_column    (i_column),
        .i_shift     (i_shift),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_value     (o_value),
        .o_component (o_component),
        .o_last      (o_last),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

`ifndef SYNTHESIS
    // A word is only loaded when the output register is free.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_status.out_free) else $error("word loaded over a waiting word");

    // Only enabled components are loaded.
    a_emit_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_status.mask[w_cmd.comp]) else $error("disabled component loaded");

    // An accepted item keeps the input side closed in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> !o_in_ready) else $error("input open while item in flight");

    // After the final word is loaded the block takes a new item.
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_cmd.last) |=> o_in_ready) else $error("input not reopened");
`endif

endmodule
